[rtl/core/recorder_command_frame_encoder_macros.svh]
// Assertion macros for the recorder command frame encoder.
// Used at the end of the top level; expects clk and arst_n in scope.
`ifndef RECORDER_COMMAND_FRAME_ENCODER_MACROS_SVH
`define RECORDER_COMMAND_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RCFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rcfe_pkg.sv]
// Shared types, constants and frame tables for the recorder command frame encoder.
// No dependencies; imported by rcfe_ctrl, rcfe_dp and the top level.
package rcfe_pkg;

	localparam logic [7:0] FRAME_MARK   = 8'h7E;
	localparam logic [7:0] NAME_LEAD    = 8'h54; // 'T'
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] OP_STOP      = 8'hD9;
	localparam logic [7:0] OP_STOP_PLAY = 8'hAB;
	localparam logic [7:0] OP_VOLUME    = 8'hAE;
	localparam logic [7:0] OP_PLAY      = 8'hA3;
	localparam logic [7:0] OP_SOURCE    = 8'hD3;
	localparam logic [7:0] OP_RATE      = 8'hD4;
	localparam logic [7:0] OP_REC_NAME  = 8'hD6;
	localparam logic [7:0] OP_DELETE    = 8'hDB;
	localparam logic [7:0] SUB_STOP_PLAY = 8'hFF;
	localparam logic [9:0] FILE_MAX     = 10'd999;
	localparam logic [7:0] SOURCE_MAX   = 8'd2;
	localparam logic [7:0] RATE_MAX     = 8'd3;

	typedef enum logic [1:0] {
		FUNC_STOP,
		FUNC_PLAY,
		FUNC_RECORD,
		FUNC_DELETE
	} func_t;

	typedef enum logic [1:0] {
		MODE_STOPPED,
		MODE_RECORDING,
		MODE_PLAYING
	} mode_t;

	typedef enum logic [1:0] {
		FRAME_SHORT,
		FRAME_VALUE,
		FRAME_NAME
	} frame_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIG_H,
		ST_DIG_R,
		ST_DIG_T,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic       load;
		logic       dig_h;
		logic       dig_r;
		logic       dig_t;
		logic       emit;
		frame_t     kind;
		logic [1:0] fidx;
		logic [3:0] bidx;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  out_free;
	} dp_status_t;

	function automatic logic [3:0] frame_len(input frame_t k);
		logic [3:0] len;
		unique case (k)
			FRAME_SHORT: len = 4'd5;
			FRAME_VALUE: len = 4'd6;
			default:     len = 4'd9;
		endcase
		return len;
	endfunction

	function automatic frame_t frame_kind(input func_t f, input logic [1:0] fidx);
		frame_t k;
		unique case (f)
			FUNC_STOP:   k = FRAME_SHORT;
			FUNC_PLAY:   k = (fidx == 2'd0) ? FRAME_VALUE : FRAME_NAME;
			FUNC_RECORD: k = (fidx != 2'd2) ? FRAME_VALUE : FRAME_NAME;
			default:     k = FRAME_NAME;
		endcase
		return k;
	endfunction

	function automatic logic [1:0] last_frame(input func_t f);
		logic [1:0] n;
		unique case (f)
			FUNC_PLAY:   n = 2'd1;
			FUNC_RECORD: n = 2'd2;
			default:     n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] query_op(input logic [7:0] sub);
		logic [7:0] op;
		unique case (sub)
			8'd1:          op = 8'hC1;
			8'd2:          op = 8'hC2;
			8'd3:          op = 8'hC5;
			8'd4:          op = 8'hC9;
			8'd5:          op = 8'hCA;
			8'd6:          op = 8'hCE;
			8'd7:          op = 8'hD0;
			8'd8:          op = 8'hD1;
			SUB_STOP_PLAY: op = OP_STOP_PLAY;
			default:       op = OP_STOP;
		endcase
		return op;
	endfunction

	function automatic mode_t next_mode(input func_t f, input logic [7:0] sub,
			input mode_t m);
		mode_t n;
		unique case (f)
			FUNC_STOP:   n = (query_op(sub) == OP_STOP) ? MODE_STOPPED : m;
			FUNC_PLAY:   n = MODE_PLAYING;
			FUNC_RECORD: n = MODE_RECORDING;
			default:     n = m;
		endcase
		return n;
	endfunction

endpackage

[rtl/core/recorder_command_frame_encoder.sv]
// Recorder command frame encoder, top level.
// Input: one command per request on s_axis; tdata = func, sub_code,
//   file_number, level, audio_source from bit 0 up.
// Output: one frame byte per request on m_axis; tdata = tx_byte, mode;
//   tlast marks the final byte of a command.
// First byte: the command is captured on the accepting edge, the file number is
//   converted to decimal digits by the shared digit unit in the hundreds, remainder
//   and tens steps, then the first byte goes into the output register.
// Bytes per command: 5 for stop or query (5-byte frame), 15 for play, 21 for
//   record, 9 for delete. The byte sequencer moves one byte per cycle while the
//   output register is free.
// One command at a time: s_axis_tready is high only while the sequencer is idle.
// A finished byte waits in the output register; while m_axis_tready is low
//   the sequencer holds and nothing is lost. A new command may be taken while
//   the final byte of the previous one still waits.
// Reset (arst_n low, asynchronous) empties the output register, returns the
//   sequencer to idle and sets the recorder mode to stopped.
// Depends on rcfe_pkg, rcfe_ctrl, rcfe_dp and the macros header.
`include "recorder_command_frame_encoder_macros.svh"
module recorder_command_frame_encoder
	import rcfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // func[1:0], sub_code[9:2], file_number[19:10],
	                                   // level[27:20], audio_source[35:28], zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // tx_byte[7:0], mode[9:8], zero
	output logic        m_axis_tlast
);

	dp_cmd_t    cmd;
	dp_status_t status;

	rcfe_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	rcfe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.cmd           (cmd),
		.status        (status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	`RCFE_ASSERT_NEXT(a_one_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second command taken while busy")
	`RCFE_ASSERT_NOW(a_last_mark, m_axis_tvalid && m_axis_tlast, m_axis_tdata[7:0] == FRAME_MARK, "command does not end on a frame mark")
	`RCFE_ASSERT_NOW(a_mode_code, m_axis_tvalid, m_axis_tdata[9:8] != 2'd3, "invalid recorder mode on output")
	`RCFE_ASSERT_NOW(a_emit_free, cmd.emit, !m_axis_tvalid || m_axis_tready, "byte emitted over a waiting one")

endmodule

[rtl/core/rcfe_ctrl.sv]
// Sequencer for the recorder command frame encoder: digit steps, then frame/byte walk.
// Depends on rcfe_pkg; drives rcfe_dp through dp_cmd_t.
module rcfe_ctrl
	import rcfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t     state_q, state_d;
	logic [1:0] fidx_q, fidx_d;
	logic [3:0] bidx_q, bidx_d;
	frame_t     kind;
	logic       end_frame;
	logic       end_cmd;

	assign kind      = frame_kind(status.func, fidx_q);
	assign end_frame = (bidx_q == frame_len(kind) - 4'd1);
	assign end_cmd   = end_frame && (fidx_q == last_frame(status.func));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fidx_q  <= '0;
			bidx_q  <= '0;
		end else begin
			state_q <= state_d;
			fidx_q  <= fidx_d;
			bidx_q  <= bidx_d;
		end
	end

	// next state and byte position
	always_comb begin
		state_d = state_q;
		fidx_d  = fidx_q;
		bidx_d  = bidx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_DIG_H;
					fidx_d  = '0;
					bidx_d  = '0;
				end
			end
			ST_DIG_H: state_d = ST_DIG_R;
			ST_DIG_R: state_d = ST_DIG_T;
			ST_DIG_T: state_d = ST_SEND;
			ST_SEND: begin
				if (status.out_free) begin
					if (end_cmd) begin
						state_d = ST_IDLE;
					end else if (end_frame) begin
						fidx_d = fidx_q + 2'd1;
						bidx_d = '0;
					end else begin
						bidx_d = bidx_q + 4'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		cmd.kind      = kind;
		cmd.fidx      = fidx_q;
		cmd.bidx      = bidx_q;
		cmd.last      = end_cmd;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load      = s_axis_tvalid;
			end
			ST_DIG_H: cmd.dig_h = 1'b1;
			ST_DIG_R: cmd.dig_r = 1'b1;
			ST_DIG_T: cmd.dig_t = 1'b1;
			ST_SEND:  cmd.emit  = status.out_free;
			default:  ;
		endcase
	end

endmodule

[rtl/core/rcfe_dp.sv]
// Datapath: command capture, decimal digits, frame byte mux, checksum, output register.
// Depends on rcfe_pkg; commanded by rcfe_ctrl.
module rcfe_dp
	import rcfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [39:0] s_axis_tdata,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	func_t       func_q;
	logic [7:0]  sub_q;
	logic [9:0]  num_q;
	logic [7:0]  lvl_q;
	logic [7:0]  src_q;
	mode_t       mode_q;
	logic [3:0]  h_q;
	logic [6:0]  r_q;
	logic [3:0]  t_q;
	logic [7:0]  sum_q;
	logic        ovalid_q;
	logic [7:0]  tx_q;
	logic        last_q;
	mode_t       omode_q;

	func_t       in_func;
	logic [7:0]  in_sub;
	logic [9:0]  in_num;
	logic [15:0] h_prod;
	logic [9:0]  r_full;
	logic [14:0] t_prod;
	logic [6:0]  ones_full;
	logic [7:0]  op;
	logic [7:0]  val;
	logic [3:0]  len;
	logic [7:0]  tx_byte;

	assign in_func = func_t'(s_axis_tdata[1:0]);
	assign in_sub  = s_axis_tdata[9:2];
	assign in_num  = s_axis_tdata[19:10];

	// n/100 as (n*41)>>12, exact below 1000; tens as (r*205)>>11, exact below 160
	assign h_prod    = 16'(num_q) * 16'd41;
	assign r_full    = num_q - 10'(h_q) * 10'd100;
	assign t_prod    = 15'(r_q) * 15'd205;
	assign ones_full = r_q - 7'(t_q) * 7'd10;

	always_comb begin
		op  = OP_DELETE;
		val = '0;
		unique case (func_q)
			FUNC_STOP: op = query_op(sub_q);
			FUNC_PLAY: begin
				op  = (cmd.fidx == 2'd0) ? OP_VOLUME : OP_PLAY;
				val = {3'b000, lvl_q[4:0]};
			end
			FUNC_RECORD: begin
				priority if (cmd.fidx == 2'd0) begin
					op  = OP_SOURCE;
					val = (src_q <= SOURCE_MAX) ? src_q : 8'd0;
				end else if (cmd.fidx == 2'd1) begin
					op  = OP_RATE;
					val = (lvl_q <= RATE_MAX) ? lvl_q : 8'd0;
				end else begin
					op  = OP_REC_NAME;
				end
			end
			default: op = OP_DELETE;
		endcase
	end

	assign len = frame_len(cmd.kind);

	always_comb begin
		priority if (cmd.bidx == 4'd0 || cmd.bidx == len - 4'd1) begin
			tx_byte = FRAME_MARK;
		end else if (cmd.bidx == len - 4'd2) begin
			tx_byte = sum_q;
		end else if (cmd.bidx == 4'd1) begin
			tx_byte = {4'b0000, len - 4'd2};
		end else if (cmd.bidx == 4'd2) begin
			tx_byte = op;
		end else if (cmd.bidx == 4'd3) begin
			tx_byte = (cmd.kind == FRAME_NAME) ? NAME_LEAD : val;
		end else if (cmd.bidx == 4'd4) begin
			tx_byte = ASCII_ZERO | {4'b0000, h_q};
		end else if (cmd.bidx == 4'd5) begin
			tx_byte = ASCII_ZERO | {4'b0000, t_q};
		end else begin
			tx_byte = ASCII_ZERO | {4'b0000, ones_full[3:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_STOPPED;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.load)
				mode_q <= next_mode(in_func, in_sub, mode_q);
			if (cmd.emit)
				ovalid_q <= 1'b1;
			else if (m_axis_tready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			sub_q  <= in_sub;
			num_q  <= (in_num > FILE_MAX) ? FILE_MAX : in_num;
			lvl_q  <= s_axis_tdata[27:20];
			src_q  <= s_axis_tdata[35:28];
		end
		if (cmd.dig_h)
			h_q <= h_prod[15:12];
		if (cmd.dig_r)
			r_q <= r_full[6:0];
		if (cmd.dig_t)
			t_q <= t_prod[14:11];
		if (cmd.emit) begin
			tx_q    <= tx_byte;
			last_q  <= cmd.last;
			omode_q <= mode_q;
			// length, opcode and payload go into the checksum
			if (cmd.bidx == 4'd0)
				sum_q <= '0;
			else if (cmd.bidx < len - 4'd2)
				sum_q <= sum_q + tx_byte;
		end
	end

	assign status.func     = func_q;
	assign status.out_free = !ovalid_q || m_axis_tready;

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {6'b000000, omode_q, tx_q};
	assign m_axis_tlast  = last_q;

endmodule
